### sv/brm_pkg.sv
package brm_pkg;

  localparam int OpWidth   = 16;
  localparam int ProdWidth = 32;
  localparam int NumRows   = 8;
  localparam int RowWidth  = OpWidth + 3;

  localparam logic [2:0] Prefix0Pos = 3'b100;
  localparam logic [2:0] Prefix0Neg = 3'b011;
  localparam logic [1:0] PrefixNPos = 2'b11;
  localparam logic [1:0] PrefixNNeg = 2'b10;

  typedef enum logic [2:0] {
    DIG_ZERO,
    DIG_POS1,
    DIG_POS2,
    DIG_NEG1,
    DIG_NEG2
  } booth_digit_t;

  typedef struct packed {
    logic [OpWidth-1:0]                  mr;
    logic [OpWidth-1:0]                  md;
    logic [ProdWidth-1:0]                sum;
    logic [NumRows-1:0][ProdWidth-1:0]   pp;
  } brm_stage_t;

  function automatic booth_digit_t booth_decode(input logic [2:0] trip);
    booth_digit_t d;
    unique case (trip)
      3'b001, 3'b010: d = DIG_POS1;
      3'b011:         d = DIG_POS2;
      3'b100:         d = DIG_NEG2;
      3'b101, 3'b110: d = DIG_NEG1;
      default:        d = DIG_ZERO;
    endcase
    return d;
  endfunction

  // prefix above the low 16 bits of the row, unshifted
  function automatic logic [RowWidth-1:0] row_word(input logic [2:0] trip,
                                                   input logic [OpWidth-1:0] md,
                                                   input logic first);
    booth_digit_t       d;
    logic [OpWidth-1:0] neg;
    logic [OpWidth:0]   row;
    logic               e;
    logic [2:0]         prefix;
    d   = booth_decode(trip);
    neg = ~md + OpWidth'(1);
    unique case (d)
      DIG_POS1: row = {md[OpWidth-1], md};
      DIG_POS2: row = {md, 1'b0};
      DIG_NEG1: row = {neg[OpWidth-1], neg};
      DIG_NEG2: row = {neg, 1'b0};
      default:  row = '0;
    endcase
    e = ~row[OpWidth];
    if (md[OpWidth-1] && (d == DIG_NEG1 || d == DIG_NEG2)) begin
      e = 1'b1;
    end
    if (first) begin
      prefix = e ? Prefix0Pos : Prefix0Neg;
    end else begin
      prefix = {1'b0, (e ? PrefixNPos : PrefixNNeg)};
    end
    return {prefix, row[OpWidth-1:0]};
  endfunction

endpackage

### sv/brm_in_if.sv
interface brm_in_if;
  import brm_pkg::*;

  logic               valid;
  logic               ready;
  logic [OpWidth-1:0] multiplier;
  logic [OpWidth-1:0] multiplicand;

  modport source(output valid, output multiplier, output multiplicand, input ready);
  modport sink(input valid, input multiplier, input multiplicand, output ready);
endinterface

### sv/brm_out_if.sv
interface brm_out_if;
  import brm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ProdWidth-1:0] product;
  logic [ProdWidth-1:0] pp_0;
  logic [ProdWidth-1:0] pp_1;
  logic [ProdWidth-1:0] pp_2;
  logic [ProdWidth-1:0] pp_3;
  logic [ProdWidth-1:0] pp_4;
  logic [ProdWidth-1:0] pp_5;
  logic [ProdWidth-1:0] pp_6;
  logic [ProdWidth-1:0] pp_7;

  modport source(output valid, output product, output pp_0, output pp_1, output pp_2,
                 output pp_3, output pp_4, output pp_5, output pp_6, output pp_7,
                 input ready);
  modport sink(input valid, input product, input pp_0, input pp_1, input pp_2,
               input pp_3, input pp_4, input pp_5, input pp_6, input pp_7,
               output ready);
endinterface

### sv/booth_radix4_multiplier_16x16.sv
// radix-4 booth multiplier, 16 x 16 bits signed, wrapping 32-bit product
//
// operands: valid/ready request of multiplier and multiplicand
// result:   valid/ready request of product and the eight shifted rows pp_0..pp_7
// a request is moved at a rising edge with valid and ready both high
//
// eight cells in a row, one per booth digit; each cell forms its row, adds it
// to the running sum and registers the lot for the next cell
// throughput: one request per cycle while the result is not stalled, eight in flight at most
// every cell has its own valid bit and takes a new request when it is empty
// or its neighbour takes its contents, so bubbles close up under stall
// when the receiver stalls, results hold on the ports and the row fills up;
// operand ready falls only once all eight cells are occupied
// reset (rst, synchronous) empties every cell; no result is shown after it
module booth_radix4_multiplier_16x16 (
  input logic      clk,
  input logic      rst,
  brm_in_if.sink   operands,
  brm_out_if.source result
);
  import brm_pkg::*;

  logic       valid [NumRows+1];
  logic       ready [NumRows+1];
  brm_stage_t data  [NumRows+1];

  always_comb begin
    data[0]     = '0;
    data[0].mr  = operands.multiplier;
    data[0].md  = operands.multiplicand;
  end
  assign valid[0]       = operands.valid;
  assign operands.ready = ready[0];

  for (genvar i = 0; i < NumRows; i++) begin : g_cell
    brm_cell #(.Row(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (valid[i]),
      .in_ready (ready[i]),
      .in_data  (data[i]),
      .out_valid(valid[i+1]),
      .out_ready(ready[i+1]),
      .out_data (data[i+1])
    );
  end

  assign result.valid   = valid[NumRows];
  assign ready[NumRows] = result.ready;
  assign result.product = data[NumRows].sum;
  assign result.pp_0    = data[NumRows].pp[0];
  assign result.pp_1    = data[NumRows].pp[1];
  assign result.pp_2    = data[NumRows].pp[2];
  assign result.pp_3    = data[NumRows].pp[3];
  assign result.pp_4    = data[NumRows].pp[4];
  assign result.pp_5    = data[NumRows].pp[5];
  assign result.pp_6    = data[NumRows].pp[6];
  assign result.pp_7    = data[NumRows].pp[7];

  a_sum_rows: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.product == result.pp_0 + result.pp_1 + result.pp_2
      + result.pp_3 + result.pp_4 + result.pp_5 + result.pp_6 + result.pp_7)
    else $error("product does not match the sum of its rows");
  a_row0_prefix: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.pp_0[18:16] == Prefix0Pos || result.pp_0[18:16] == Prefix0Neg)
    else $error("bad prefix on row 0");
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !operands.ready |-> result.valid && !result.ready)
    else $error("operand request refused without a stalled result");

endmodule

### sv/brm_cell.sv
module brm_cell #(
  parameter int Row = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  brm_pkg::brm_stage_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output brm_pkg::brm_stage_t out_data
);
  import brm_pkg::*;

  logic [OpWidth:0]      ext;
  logic [2:0]            trip;
  logic [RowWidth-1:0]   raw;
  logic [ProdWidth-1:0]  word;
  brm_stage_t            data_next;

  assign ext  = {in_data.mr, 1'b0};
  assign trip = ext[2*Row +: 3];
  assign raw  = row_word(trip, in_data.md, (Row == 0));
  assign word = ProdWidth'(raw) << (2 * Row);

  always_comb begin
    data_next         = in_data;
    data_next.sum     = in_data.sum + word;
    data_next.pp[Row] = word;
  end

  assign in_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request did not reach cell output");
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled cell lost its contents");
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("empty cell refused a request");

endmodule
